### hdl/skfm_pkg.sv
// shared types and constants for the sorted key first match lookup block
`default_nettype none

package skfm_pkg;

    // field widths of the stream items
    localparam int OPCODE_W    = 2;
    localparam int INDEX_W     = 12;
    localparam int CODE_W      = 16;
    localparam int STATUS_W    = 3;
    localparam int COUNT_W     = 13;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 16;

    // positions and counts are carried wide enough for the largest table
    localparam int POS_W = 17;
    localparam int SUM_W = POS_W + 1;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [CODE_W-1:0] NO_CODE = '1;

    localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_FIND  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_TOWN  = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_NONE  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_ID   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MISMATCH = 3'd4;

    typedef enum logic [1:0] {
        K_WRITE = 2'd0,
        K_FIND  = 2'd1,
        K_TOWN  = 2'd2,
        K_IMMED = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic [STATUS_W-1:0]  status;
        logic [INDEX_W-1:0]   idx;
        logic [CODE_W-1:0]    city;
        logic [CODE_W-1:0]    town;
    } item_t;

    typedef struct packed {
        logic  push;
        item_t item;
    } push_t;

endpackage

`default_nettype wire

### hdl/skfm_front.sv
// front end: takes input beats and sorts them into work for the back end
`default_nettype none

module skfm_front #(
    parameter int TABLE_DEPTH = 4096
) (
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [skfm_pkg::OPCODE_W-1:0]      s_tuser,   // opcode
    input  wire logic [skfm_pkg::IN_TDATA_W-1:0]    s_tdata,   // entry_index, city_id, town_id
    input  wire logic                               q_full,
    output skfm_pkg::push_t                         q_push
);

    logic [skfm_pkg::INDEX_W-1:0] idx_c;
    logic [skfm_pkg::CODE_W-1:0]  city_c;
    logic [skfm_pkg::CODE_W-1:0]  town_c;
    logic                         idx_ok_c;
    skfm_pkg::item_t              item_c;

    assign idx_c  = s_tdata[skfm_pkg::INDEX_W-1:0];
    assign city_c = s_tdata[skfm_pkg::INDEX_W +: skfm_pkg::CODE_W];
    assign town_c = s_tdata[skfm_pkg::INDEX_W + skfm_pkg::CODE_W +: skfm_pkg::CODE_W];

    assign idx_ok_c = skfm_pkg::POS_W'(idx_c) < skfm_pkg::POS_W'(TABLE_DEPTH);

    always_comb begin
        item_c.idx    = idx_c;
        item_c.city   = city_c;
        item_c.town   = town_c;
        item_c.status = skfm_pkg::ST_OK;
        item_c.kind   = skfm_pkg::K_IMMED;
        unique case (s_tuser)
            skfm_pkg::OP_WRITE: begin
                if (idx_ok_c) begin
                    item_c.kind = skfm_pkg::K_WRITE;
                end else begin
                    item_c.status = skfm_pkg::ST_RANGE;
                end
            end
            skfm_pkg::OP_FIND: begin
                if (city_c == skfm_pkg::NO_CODE) begin
                    item_c.status = skfm_pkg::ST_BAD_ID;
                end else begin
                    item_c.kind = skfm_pkg::K_FIND;
                end
            end
            skfm_pkg::OP_TOWN: begin
                if (city_c == skfm_pkg::NO_CODE || town_c == skfm_pkg::NO_CODE) begin
                    item_c.status = skfm_pkg::ST_BAD_ID;
                end else begin
                    item_c.kind = skfm_pkg::K_TOWN;
                end
            end
            default: begin
                item_c.status = skfm_pkg::ST_BAD_ID;
            end
        endcase
    end

    assign s_tready    = !q_full;
    assign q_push.push = s_tvalid && !q_full;
    assign q_push.item = item_c;

endmodule

`default_nettype wire

### hdl/skfm_queue.sv
// short fifo of classified work items between front and back end
`default_nettype none

module skfm_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire skfm_pkg::push_t    q_push,
    output logic                    q_full,
    output logic                    q_valid,
    output skfm_pkg::item_t         q_item,
    input  wire logic               q_pop
);

    localparam int PTR_W = $clog2(skfm_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(skfm_pkg::QUEUE_DEPTH + 1);

    skfm_pkg::item_t   slot_reg [skfm_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign q_full  = count_reg == CNT_W'(skfm_pkg::QUEUE_DEPTH);
    assign q_valid = count_reg != '0;
    assign q_item  = slot_reg[rd_ptr_reg];

    assign do_push = q_push.push && !q_full;
    assign do_pop  = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(skfm_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(skfm_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= q_push.item;
        end
    end

endmodule

`default_nettype wire

### hdl/skfm_back.sv
// back end: record stores, first-position memo, search sequencer and result register
`default_nettype none

module skfm_back #(
    parameter int TABLE_DEPTH = 4096,
    parameter int CITY_SLOTS  = 256
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_we,
    input  wire logic [skfm_pkg::POS_W-1:0]         live_count,
    input  wire logic                               q_valid,
    input  wire skfm_pkg::item_t                    q_item,
    output logic                                    q_pop,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [skfm_pkg::OUT_TDATA_W-1:0]        m_tdata
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int MW = $clog2(CITY_SLOTS);
    localparam int PW = skfm_pkg::POS_W;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_MEMO     = 11'b000_0000_0010,
        S_FIRST    = 11'b000_0000_0100,
        S_LAST     = 11'b000_0000_1000,
        S_LASTPREV = 11'b000_0001_0000,
        S_LOOP     = 11'b000_0010_0000,
        S_MID      = 11'b000_0100_0000,
        S_MIDPREV  = 11'b000_1000_0000,
        S_FOUND    = 11'b001_0000_0000,
        S_TOWN     = 11'b010_0000_0000,
        S_RESULT   = 11'b100_0000_0000
    } state_t;

    state_t st_reg, st_next;

    logic [skfm_pkg::CODE_W-1:0]  city_mem [TABLE_DEPTH];
    logic [skfm_pkg::CODE_W-1:0]  town_mem [TABLE_DEPTH];
    logic [skfm_pkg::INDEX_W-1:0] memo_mem [CITY_SLOTS];
    logic [CITY_SLOTS-1:0]        memo_valid_reg;

    logic [skfm_pkg::CODE_W-1:0]  city_rd_reg;
    logic [skfm_pkg::CODE_W-1:0]  town_rd_reg;
    logic [skfm_pkg::INDEX_W-1:0] memo_rd_reg;

    skfm_pkg::item_t              cur_reg, cur_next;
    logic [PW-1:0]                lo_reg, lo_next;
    logic [PW-1:0]                hi_reg, hi_next;
    logic [PW-1:0]                mid_reg, mid_next;
    logic [PW-1:0]                first_reg, first_next;
    logic [PW-1:0]                sum_reg, sum_next;
    logic [skfm_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [skfm_pkg::INDEX_W-1:0]  res_pos_reg, res_pos_next;
    logic                         m_tvalid_reg;
    logic [skfm_pkg::OUT_TDATA_W-1:0] m_tdata_reg;

    logic [PW-1:0]                city_rd_addr;
    logic [skfm_pkg::SUM_W-1:0]   town_rd_addr;
    logic [PW-1:0]                wr_addr;
    logic                         mem_we;
    logic [PW-1:0]                q_city_w;
    logic [PW-1:0]                cur_city_w;
    logic [MW-1:0]                memo_rd_slot;
    logic [MW-1:0]                cur_slot;
    logic                         cur_small;
    logic                         memo_clr;
    logic                         memo_set;
    logic                         found_c;
    logic [PW-1:0]                found_pos_c;
    logic                         absent_c;
    logic                         out_load;
    logic [skfm_pkg::SUM_W-1:0]   mid_sum_c;
    logic [skfm_pkg::SUM_W-1:0]   town_sum_c;

    assign q_city_w     = PW'(q_item.city);
    assign cur_city_w   = PW'(cur_reg.city);
    assign cur_small    = cur_city_w < PW'(CITY_SLOTS);
    assign cur_slot     = cur_city_w[MW-1:0];
    assign memo_rd_slot = (st_reg == S_IDLE) ? q_city_w[MW-1:0] : cur_slot;
    assign wr_addr      = PW'(q_item.idx);
    assign out_load     = (st_reg == S_RESULT) && (!m_tvalid_reg || m_tready);
    assign mid_sum_c    = skfm_pkg::SUM_W'(hi_reg) + skfm_pkg::SUM_W'(lo_reg);
    assign town_sum_c   = skfm_pkg::SUM_W'(first_reg) + skfm_pkg::SUM_W'(cur_reg.town);

    always_comb begin
        st_next         = st_reg;
        cur_next        = cur_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        first_next      = first_reg;
        sum_next        = sum_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        q_pop           = 1'b0;
        mem_we          = 1'b0;
        memo_clr        = 1'b0;
        city_rd_addr    = '0;
        town_rd_addr    = '0;
        found_c         = 1'b0;
        found_pos_c     = '0;
        absent_c        = 1'b0;

        unique case (st_reg)
            S_IDLE: begin
                if (q_valid) begin
                    q_pop    = 1'b1;
                    cur_next = q_item;
                    unique case (q_item.kind)
                        skfm_pkg::K_WRITE: begin
                            mem_we          = 1'b1;
                            memo_clr        = 1'b1;
                            res_status_next = skfm_pkg::ST_OK;
                            res_pos_next    = q_item.idx;
                            st_next         = S_RESULT;
                        end
                        skfm_pkg::K_IMMED: begin
                            res_status_next = q_item.status;
                            res_pos_next    = '0;
                            st_next         = S_RESULT;
                        end
                        skfm_pkg::K_FIND, skfm_pkg::K_TOWN: begin
                            st_next = S_MEMO;
                        end
                    endcase
                end
            end
            S_MEMO: begin
                if (cur_small && memo_valid_reg[cur_slot]) begin
                    first_next = PW'(memo_rd_reg);
                    st_next    = S_FOUND;
                end else if (live_count == '0) begin
                    absent_c = 1'b1;
                end else begin
                    lo_next      = '0;
                    hi_next      = live_count - PW'(1);
                    city_rd_addr = '0;
                    st_next      = S_FIRST;
                end
            end
            S_FIRST: begin
                if (live_count == PW'(1)) begin
                    if (city_rd_reg == cur_reg.city) begin
                        found_c = 1'b1;
                    end else begin
                        absent_c = 1'b1;
                    end
                end else if (city_rd_reg == cur_reg.city) begin
                    found_c = 1'b1;
                end else if (city_rd_reg > cur_reg.city) begin
                    absent_c = 1'b1;
                end else begin
                    city_rd_addr = hi_reg;
                    st_next      = S_LAST;
                end
            end
            S_LAST: begin
                if (city_rd_reg == cur_reg.city) begin
                    if (hi_reg == PW'(1)) begin
                        found_c     = 1'b1;
                        found_pos_c = hi_reg;
                    end else begin
                        city_rd_addr = hi_reg - PW'(1);
                        st_next      = S_LASTPREV;
                    end
                end else if (city_rd_reg < cur_reg.city || city_rd_reg == skfm_pkg::NO_CODE) begin
                    absent_c = 1'b1;
                end else begin
                    st_next = S_LOOP;
                end
            end
            S_LASTPREV: begin
                if (city_rd_reg != cur_reg.city) begin
                    found_c     = 1'b1;
                    found_pos_c = hi_reg;
                end else begin
                    st_next = S_LOOP;
                end
            end
            S_LOOP: begin
                if (hi_reg - lo_reg >= PW'(2)) begin
                    mid_next     = mid_sum_c[PW:1];
                    city_rd_addr = mid_sum_c[PW:1];
                    st_next      = S_MID;
                end else begin
                    absent_c = 1'b1;
                end
            end
            S_MID: begin
                if (city_rd_reg == cur_reg.city) begin
                    if (lo_reg + PW'(1) == mid_reg) begin
                        found_c     = 1'b1;
                        found_pos_c = mid_reg;
                    end else begin
                        city_rd_addr = mid_reg - PW'(1);
                        st_next      = S_MIDPREV;
                    end
                end else if (city_rd_reg > cur_reg.city) begin
                    hi_next = mid_reg;
                    st_next = S_LOOP;
                end else begin
                    lo_next = mid_reg;
                    st_next = S_LOOP;
                end
            end
            S_MIDPREV: begin
                if (city_rd_reg != cur_reg.city) begin
                    found_c     = 1'b1;
                    found_pos_c = mid_reg;
                end else begin
                    hi_next = mid_reg;
                    st_next = S_LOOP;
                end
            end
            S_FOUND: begin
                if (cur_reg.kind == skfm_pkg::K_FIND) begin
                    res_status_next = skfm_pkg::ST_OK;
                    res_pos_next    = first_reg[skfm_pkg::INDEX_W-1:0];
                    st_next         = S_RESULT;
                end else if (town_sum_c >= skfm_pkg::SUM_W'(live_count)) begin
                    res_status_next = skfm_pkg::ST_RANGE;
                    res_pos_next    = '0;
                    st_next         = S_RESULT;
                end else begin
                    town_rd_addr = town_sum_c;
                    sum_next     = town_sum_c[PW-1:0];
                    st_next      = S_TOWN;
                end
            end
            S_TOWN: begin
                if (town_rd_reg == cur_reg.town) begin
                    res_status_next = skfm_pkg::ST_OK;
                    res_pos_next    = sum_reg[skfm_pkg::INDEX_W-1:0];
                end else begin
                    res_status_next = skfm_pkg::ST_MISMATCH;
                    res_pos_next    = '0;
                end
                st_next = S_RESULT;
            end
            S_RESULT: begin
                if (out_load) begin
                    st_next = S_IDLE;
                end
            end
            default: begin
                st_next = S_IDLE;
            end
        endcase

        if (found_c) begin
            first_next = found_pos_c;
            st_next    = S_FOUND;
        end
        if (absent_c) begin
            res_status_next = skfm_pkg::ST_ABSENT;
            res_pos_next    = '0;
            st_next         = S_RESULT;
        end
    end

    // only successful searches of small cities are remembered
    assign memo_set = found_c && cur_small;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg         <= S_IDLE;
            memo_valid_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (cfg_we || memo_clr) begin
                memo_valid_reg <= '0;
            end else if (memo_set) begin
                memo_valid_reg[cur_slot] <= 1'b1;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg        <= cur_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        first_reg      <= first_next;
        sum_reg        <= sum_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        if (out_load) begin
            m_tdata_reg <= skfm_pkg::OUT_TDATA_W'({res_pos_reg, res_status_reg});
        end
    end

    // record stores, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            city_mem[wr_addr[AW-1:0]] <= q_item.city;
            town_mem[wr_addr[AW-1:0]] <= q_item.town;
        end
        city_rd_reg <= city_mem[city_rd_addr[AW-1:0]];
        town_rd_reg <= town_mem[town_rd_addr[AW-1:0]];
    end

    // memo of first positions, registered read
    always_ff @(posedge aclk) begin
        if (memo_set) begin
            memo_mem[cur_slot] <= found_pos_c[skfm_pkg::INDEX_W-1:0];
        end
        memo_rd_reg <= memo_mem[memo_rd_slot];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_fail_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tdata_reg[skfm_pkg::STATUS_W-1:0] != skfm_pkg::ST_OK)
        |-> m_tdata_reg[skfm_pkg::STATUS_W +: skfm_pkg::INDEX_W] == '0)
        else $error("failed result carries a nonzero position");

    a_write_clears_memo: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == S_IDLE && q_valid && q_item.kind == skfm_pkg::K_WRITE)
        |=> memo_valid_reg == '0)
        else $error("memo survived a record write");

    a_probe_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == S_MID) |-> (lo_reg < mid_reg && mid_reg < hi_reg && hi_reg < live_count))
        else $error("search probe outside its window");

    a_town_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == S_TOWN) |-> sum_reg < live_count)
        else $error("town record read beyond the record count");

    a_no_pop_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop) |-> (st_reg == S_IDLE && q_valid))
        else $error("queue popped while an item is in work");

endmodule

`default_nettype wire

### hdl/sorted_key_first_match_lookup_top.sv
// top level of the sorted key first match lookup block
//
// Holds up to TABLE_DEPTH town records (city code, town code) kept sorted by
// city code by the writer, and answers first-of-city and town-by-number
// queries with a lower-bound binary search. Each beat on s_ is one item and
// gives exactly one result beat on m_, in order. A front end classifies beats
// into a two-entry queue; the back end works one item at a time. A record
// write or a rejected beat goes from idle straight to the result register; a
// query whose city is in the first-position memo skips the search; a full
// search narrows its window probe by probe, each probe costing a window step
// plus a registered read of the city store, and a hit costs one more read of
// the entry before it. Writing town_count or any record clears the memo.
`default_nettype none

module sorted_key_first_match_lookup_top #(
    parameter int TABLE_DEPTH = 4096,
    parameter int CITY_SLOTS  = 256
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_we,
    input  wire logic [skfm_pkg::COUNT_W-1:0]       cfg_wdata,  // town_count
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [skfm_pkg::OPCODE_W-1:0]      s_tuser,    // opcode
    input  wire logic [skfm_pkg::IN_TDATA_W-1:0]    s_tdata,    // entry_index, city_id, town_id
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [skfm_pkg::OUT_TDATA_W-1:0]        m_tdata     // status, position
);

    logic [skfm_pkg::COUNT_W-1:0] town_count_reg;
    logic [skfm_pkg::POS_W-1:0]   count_w;
    logic [skfm_pkg::POS_W-1:0]   live_count;
    skfm_pkg::push_t              q_push;
    logic                         q_full;
    logic                         q_valid;
    skfm_pkg::item_t              q_item;
    logic                         q_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            town_count_reg <= '0;
        end else if (cfg_we) begin
            town_count_reg <= cfg_wdata;
        end
    end

    // counts above the table size act as a full table
    assign count_w    = skfm_pkg::POS_W'(town_count_reg);
    assign live_count = (count_w > skfm_pkg::POS_W'(TABLE_DEPTH)) ? skfm_pkg::POS_W'(TABLE_DEPTH)
                                                                  : count_w;

    skfm_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push)
    );

    skfm_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_push  (q_push),
        .q_full  (q_full),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    skfm_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .CITY_SLOTS  (CITY_SLOTS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .live_count (live_count),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

`default_nettype wire
